// ===== design/grs_pkg.sv =====
`timescale 1ns / 1ps
package grs_pkg;
  localparam int GRID_MAX = 128;
  localparam int IDX_W = $clog2(GRID_MAX);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int CELL_W = 40;
  localparam int SIZE_W = 8;
  localparam int SWEEP_W = 16;
  localparam int SCALE_W = 32;
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd8;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [1:0] CFG_SWEEP_COUNT = 2'd1;
  localparam logic [1:0] CFG_SOURCE_SCALE = 2'd2;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic host_wr;
    logic host_rd;
    logic load_read;
    logic load_done;
    logic cell_step;
    logic mul_lo;
    logic mul_hi;
    logic fin;
    logic wr_cell;
    logic copy_wr;
    logic toggle;
    logic [STEP_W-1:0] step;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
  } cmd_t;
endpackage

// ===== design/grid_relaxation_stencil_top.sv =====
`timescale 1ns / 1ps
// Jacobi relaxation engine on a square grid of signed Q23.16 cells.
// The input channel (in_valid/in_stall) carries items with op, row, col and
// cell_in. A write item stores cell_in as both the cell value and its source
// term and gives no result. A read item returns the cell on the output
// channel (out_valid/out_stall) from the registered read port through the
// output register, with is_read_reply set. A run item performs sweep_count
// sweeps over the grid_size by grid_size grid (grid_size capped at 128) and
// then returns one result with cell_out zero and is_read_reply clear. In each
// sweep every interior cell streams its eight neighbor reads through the
// registered read port, forms the source product in halves on the shared
// multiplier, combines and writes back. After the last sweep a copy pass
// over the interior cells brings the idle bank up to date before the
// result appears.
// Only one item is in flight; the input stalls until it finishes and while a
// result is waiting in the output register under out_stall.
// The configuration port (cfg_we, cfg_index, cfg_data) writes grid_size,
// sweep_count and source_scale with no wait. Synchronous reset restores the
// register defaults and empties the output; grid contents are not cleared.
module grid_relaxation_stencil_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] op,
  input  logic [6:0] row,
  input  logic [6:0] col,
  input  logic signed [39:0] cell_in,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [39:0] cell_out,
  output logic is_read_reply,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import grs_pkg::*;

  cmd_t cmd;

  grs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_busy(out_valid && out_stall), .cmd(cmd)
  );

  grs_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .row(row), .col(col), .cell_in(cell_in),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_stall(out_stall), .out_valid(out_valid), .cell_out(cell_out),
    .is_read_reply(is_read_reply)
  );
endmodule

// ===== design/grs_ctrl.sv =====
`timescale 1ns / 1ps
module grs_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] op,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic out_busy,
  output grs_pkg::cmd_t cmd
);
  import grs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDW = 4'd1;
  localparam logic [3:0] S_CELL = 4'd2;
  localparam logic [3:0] S_MLO = 4'd3;
  localparam logic [3:0] S_MHI = 4'd4;
  localparam logic [3:0] S_FIN = 4'd5;
  localparam logic [3:0] S_WRC = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_CPR = 4'd8;
  localparam logic [3:0] S_CPW = 4'd9;

  logic [3:0] state;
  logic [SIZE_W-1:0] grid_size;
  logic [SWEEP_W-1:0] sweep_count;
  logic [SWEEP_W-1:0] sweeps_left;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0] r;
  logic [IDX_W-1:0] c;
  logic [SIZE_W-1:0] n_eff;
  logic [SIZE_W-1:0] last_idx;
  logic accept;

  assign n_eff = (grid_size > SIZE_W'(GRID_MAX)) ? SIZE_W'(GRID_MAX) : grid_size;
  assign last_idx = n_eff - SIZE_W'(2);
  assign in_stall = (state != S_IDLE) || out_busy;
  assign accept = in_valid && !in_stall;

  // Configuration registers held by the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= SIZE_W'(128);
      sweep_count <= SWEEP_W'(1001);
    end else if (cfg_we) begin
      if (cfg_index == CFG_GRID_SIZE) grid_size <= cfg_data[SIZE_W-1:0];
      if (cfg_index == CFG_SWEEP_COUNT) sweep_count <= cfg_data[SWEEP_W-1:0];
    end
  end

  // Sequencer over sweeps, rows, columns and stencil steps, then a copy pass
  // that makes both banks agree on the interior before the run answers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      r <= '0;
      c <= '0;
      sweeps_left <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_READ) begin
              state <= S_RDW;
            end else if (op == OP_RUN) begin
              if (n_eff < SIZE_W'(3) || sweep_count == '0) begin
                state <= S_DONE;
              end else begin
                sweeps_left <= sweep_count;
                r <= IDX_W'(1);
                c <= IDX_W'(1);
                step <= '0;
                state <= S_CELL;
              end
            end
          end
        end
        S_RDW: state <= S_IDLE;
        S_CELL: begin
          if (step == LAST_STEP) state <= S_MLO;
          else step <= step + STEP_W'(1);
        end
        S_MLO: state <= S_MHI;
        S_MHI: state <= S_FIN;
        S_FIN: state <= S_WRC;
        S_WRC: begin
          if ({1'b0, c} == last_idx) begin
            c <= IDX_W'(1);
            if ({1'b0, r} == last_idx) begin
              r <= IDX_W'(1);
              sweeps_left <= sweeps_left - SWEEP_W'(1);
              if (sweeps_left == SWEEP_W'(1)) begin
                step <= LAST_STEP;
                state <= S_CPR;
              end else begin
                step <= '0;
                state <= S_CELL;
              end
            end else begin
              r <= r + IDX_W'(1);
              step <= '0;
              state <= S_CELL;
            end
          end else begin
            c <= c + IDX_W'(1);
            step <= '0;
            state <= S_CELL;
          end
        end
        S_CPR: state <= S_CPW;
        S_CPW: begin
          if ({1'b0, c} == last_idx) begin
            c <= IDX_W'(1);
            if ({1'b0, r} == last_idx) begin
              r <= IDX_W'(1);
              state <= S_DONE;
            end else begin
              r <= r + IDX_W'(1);
              state <= S_CPR;
            end
          end else begin
            c <= c + IDX_W'(1);
            state <= S_CPR;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd = '0;
    cmd.step = step;
    cmd.r = r;
    cmd.c = c;
    cmd.host_wr = accept && (op == OP_WRITE);
    cmd.host_rd = accept && (op == OP_READ);
    cmd.load_read = (state == S_RDW);
    cmd.load_done = (state == S_DONE);
    cmd.cell_step = (state == S_CELL);
    cmd.mul_lo = (state == S_MLO);
    cmd.mul_hi = (state == S_MHI);
    cmd.fin = (state == S_FIN);
    cmd.wr_cell = (state == S_WRC);
    cmd.copy_wr = (state == S_CPW);
    cmd.toggle = (state == S_WRC) && ({1'b0, c} == last_idx) && ({1'b0, r} == last_idx);
  end
endmodule

// ===== design/grs_datapath.sv =====
`timescale 1ns / 1ps
module grs_datapath (
  input  logic clk,
  input  logic rst,
  input  grs_pkg::cmd_t cmd,
  input  logic [grs_pkg::IDX_W-1:0] row,
  input  logic [grs_pkg::IDX_W-1:0] col,
  input  logic signed [grs_pkg::CELL_W-1:0] cell_in,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic out_stall,
  output logic out_valid,
  output logic signed [grs_pkg::CELL_W-1:0] cell_out,
  output logic is_read_reply
);
  import grs_pkg::*;

  localparam int PW = 60;
  localparam logic signed [PW-1:0] MAX40 = PW'(64'sd549755813887);
  localparam logic signed [PW-1:0] MIN40 = -PW'(64'sd549755813888);

  logic [CELL_W-1:0] bank0 [GRID_MAX*GRID_MAX];
  logic [CELL_W-1:0] bank1 [GRID_MAX*GRID_MAX];
  logic [CELL_W-1:0] srcm [GRID_MAX*GRID_MAX];
  logic [CELL_W-1:0] rd0, rd1, rds;
  logic cur;
  logic [SCALE_W-1:0] scale;
  logic [15:0] scale_half;
  logic [ADDR_W-1:0] rd_addr, wr_addr, nbr_addr;
  logic [IDX_W-1:0] nr, nc;
  logic signed [CELL_W-1:0] rd_cur;
  logic signed [CELL_W-1:0] src;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] acc, prod_lo, prod_hi, part;
  logic signed [PW-1:0] sum, shifted;
  logic signed [CELL_W-1:0] result;
  logic [CELL_W-1:0] wr_data;
  logic wr_other;
  logic wr_new;

  // Neighbor offsets in stencil order, row-major around the center.
  always_comb begin
    nr = cmd.r;
    nc = cmd.c;
    case (cmd.step)
      4'd0: begin nr = cmd.r - 1'b1; nc = cmd.c - 1'b1; end
      4'd1: begin nr = cmd.r - 1'b1; end
      4'd2: begin nr = cmd.r - 1'b1; nc = cmd.c + 1'b1; end
      4'd3: begin nc = cmd.c - 1'b1; end
      4'd4: begin nc = cmd.c + 1'b1; end
      4'd5: begin nr = cmd.r + 1'b1; nc = cmd.c - 1'b1; end
      4'd6: begin nr = cmd.r + 1'b1; end
      4'd7: begin nr = cmd.r + 1'b1; nc = cmd.c + 1'b1; end
      default: begin end
    endcase
  end

  assign nbr_addr = {nr, nc};
  assign rd_addr = cmd.host_rd ? {row, col} : nbr_addr;
  assign wr_addr = cmd.host_wr ? {row, col} : {cmd.r, cmd.c};
  assign rd_cur = cur ? $signed(rd1) : $signed(rd0);

  // New stencil values and the closing copy both go to the bank not in use.
  assign wr_other = cmd.wr_cell || cmd.copy_wr;
  assign wr_data = cmd.host_wr ? cell_in : (cmd.copy_wr ? rd_cur : result);

  // Grid banks and source store, one write and one registered read each.
  always_ff @(posedge clk) begin
    if (cmd.host_wr || (wr_other && !cur)) bank1[wr_addr] <= wr_data;
    if (cmd.host_wr || (wr_other && cur)) bank0[wr_addr] <= wr_data;
    if (cmd.host_wr) srcm[wr_addr] <= cell_in;
    rd0 <= bank0[rd_addr];
    rd1 <= bank1[rd_addr];
    rds <= srcm[{cmd.r, cmd.c}];
  end

  // Bank select and source scale register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= 1'b0;
      scale <= SCALE_W'(258096);
    end else begin
      if (cmd.toggle) cur <= ~cur;
      if (cfg_we && cfg_index == CFG_SOURCE_SCALE) scale <= cfg_data;
    end
  end

  // One multiplier serves both halves of the scale in turn.
  assign scale_half = cmd.mul_hi ? scale[31:16] : scale[15:0];
  assign prod = PW'(src * $signed({1'b0, scale_half}));

  // Stencil accumulation and the split source product.
  always_ff @(posedge clk) begin
    if (cmd.cell_step) begin
      if (cmd.step == '0) acc <= '0;
      else acc <= acc + PW'(rd_cur);
      if (cmd.step == STEP_W'(1)) src <= $signed(rds);
    end
    if (cmd.mul_lo) prod_lo <= prod;
    if (cmd.mul_hi) prod_hi <= prod;
    if (cmd.fin) part <= prod_hi + (prod_lo >>> 16);
  end

  assign sum = acc + (part >>> 16);
  assign shifted = sum >>> 3;
  assign result = (shifted > MAX40) ? MAX40[CELL_W-1:0] :
                  (shifted < MIN40) ? MIN40[CELL_W-1:0] : shifted[CELL_W-1:0];
  assign wr_new = cmd.load_read || cmd.load_done;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_new) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_new) begin
      cell_out <= cmd.load_read ? rd_cur : '0;
      is_read_reply <= cmd.load_read;
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import grs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [39:0] CELL_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] CELL_MIN = -40'sh80_0000_0000;
  localparam int WATCHDOG_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic signed [39:0] val;
    logic read_reply;
  } reply_t;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] row;
    logic [6:0] col;
    logic signed [39:0] val;
    logic typed;
    logic signed [39:0] want_cell;
    logic want_read;
  } dir_row_t;

  localparam int DIR_ROWS = 17;
  // Directed items on a 3 by 3 grid: extremes, far corners, one sweep, unused op.
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{OP_WRITE, 7'd0, 7'd0, CELL_MAX, 1'b0, 40'sd0, 1'b0},
    '{OP_WRITE, 7'd0, 7'd1, CELL_MIN, 1'b0, 40'sd0, 1'b0},
    '{OP_WRITE, 7'd0, 7'd2, 40'sd0, 1'b0, 40'sd0, 1'b0},
    '{OP_WRITE, 7'd1, 7'd0, -40'sd1, 1'b0, 40'sd0, 1'b0},
    '{OP_WRITE, 7'd1, 7'd1, 40'sd1234, 1'b0, 40'sd0, 1'b0},
    '{OP_WRITE, 7'd1, 7'd2, CELL_MAX, 1'b0, 40'sd0, 1'b0},
    '{OP_WRITE, 7'd2, 7'd0, CELL_MAX, 1'b0, 40'sd0, 1'b0},
    '{OP_WRITE, 7'd2, 7'd1, CELL_MAX, 1'b0, 40'sd0, 1'b0},
    '{OP_WRITE, 7'd2, 7'd2, CELL_MIN + 40'sd1, 1'b0, 40'sd0, 1'b0},
    '{OP_READ, 7'd0, 7'd1, 40'sd0, 1'b1, CELL_MIN, 1'b1},
    '{OP_WRITE, 7'd127, 7'd127, 40'sh55_5555_5555, 1'b0, 40'sd0, 1'b0},
    '{OP_READ, 7'd127, 7'd127, -40'sd1, 1'b1, 40'sh55_5555_5555, 1'b1},
    '{OP_WRITE, 7'd127, 7'd0, -40'sd1, 1'b0, 40'sd0, 1'b0},
    '{OP_READ, 7'd127, 7'd0, CELL_MAX, 1'b1, -40'sd1, 1'b1},
    '{OP_RUN, 7'd0, 7'd0, 40'sd0, 1'b1, 40'sd0, 1'b0},
    '{OP_READ, 7'd1, 7'd1, 40'sd0, 1'b0, 40'sd0, 1'b0},
    '{OP_UNUSED, 7'd1, 7'd1, 40'sd0, 1'b0, 40'sd0, 1'b0}
  };

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] op;
  logic [6:0] row;
  logic [6:0] col;
  logic signed [39:0] cell_in;
  logic out_valid;
  logic out_stall;
  logic signed [39:0] cell_out;
  logic is_read_reply;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  // Predictor state: grid values, source terms and register copies.
  logic signed [39:0] grid_now [0:GRID_MAX*GRID_MAX-1];
  logic signed [39:0] grid_old [0:GRID_MAX*GRID_MAX-1];
  logic signed [39:0] source_term [0:GRID_MAX*GRID_MAX-1];
  bit cell_written [0:GRID_MAX*GRID_MAX-1];
  logic [7:0] size_reg;
  logic [15:0] sweeps_reg;
  logic [31:0] scale_reg;

  reply_t reply_q[$];
  int send_idle;
  int recv_idle;
  int mismatches = 0;
  int quiet_cycles;

  grid_relaxation_stencil_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .row(row), .col(col), .cell_in(cell_in),
    .out_valid(out_valid), .out_stall(out_stall), .cell_out(cell_out),
    .is_read_reply(is_read_reply),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Source term times scale, floored back to Q23.16.
  function automatic longint scaled_source(logic signed [39:0] s);
    logic signed [79:0] a;
    logic signed [79:0] b;
    logic signed [79:0] p;
    a = 80'(s);
    b = {48'd0, scale_reg};
    p = (a * b) >>> 32;
    return longint'(p);
  endfunction

  // Jacobi sweeps over the grid in use, saturating each interior cell.
  task automatic relax_grid();
    int n;
    longint sum;
    n = (size_reg > GRID_MAX) ? GRID_MAX : size_reg;
    if (n >= 3) begin
      for (int s = 0; s < sweeps_reg; s++) begin
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++) grid_old[r*GRID_MAX+c] = grid_now[r*GRID_MAX+c];
        for (int r = 1; r < n - 1; r++) begin
          for (int c = 1; c < n - 1; c++) begin
            sum = 0;
            for (int dr = -1; dr <= 1; dr++)
              for (int dc = -1; dc <= 1; dc++)
                if (dr != 0 || dc != 0) sum += grid_old[(r+dr)*GRID_MAX + c + dc];
            sum += scaled_source(source_term[r*GRID_MAX+c]);
            sum = sum >>> 3;
            if (sum > longint'(CELL_MAX)) sum = longint'(CELL_MAX);
            else if (sum < longint'(CELL_MIN)) sum = longint'(CELL_MIN);
            grid_now[r*GRID_MAX+c] = sum[39:0];
          end
        end
      end
    end
  endtask

  // Update the predictor for one accepted item and work out its reply.
  task automatic predict_item(input logic [1:0] o, input logic [6:0] r, input logic [6:0] c,
                              input logic signed [39:0] v, output bit has_reply,
                              output reply_t rep);
    int a;
    a = r * GRID_MAX + c;
    has_reply = 1'b0;
    rep = '0;
    case (o)
      OP_WRITE: begin
        grid_now[a] = v;
        grid_old[a] = v;
        source_term[a] = v;
        cell_written[a] = 1'b1;
      end
      OP_RUN: begin
        relax_grid();
        has_reply = 1'b1;
      end
      OP_READ: begin
        has_reply = 1'b1;
        rep.val = grid_now[a];
        rep.read_reply = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Hand one item to the block, with an optional random gap before it.
  task automatic send_item(input logic [1:0] o, input logic [6:0] r, input logic [6:0] c,
                           input logic signed [39:0] v, input bit typed, input reply_t want);
    bit has_reply;
    reply_t rep;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    row <= r;
    col <= c;
    cell_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(o, r, c, v, has_reply, rep);
    if (typed) rep = want;
    if (has_reply) reply_q.push_back(rep);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_SIZE: size_reg = data[7:0];
      CFG_SWEEP_COUNT: sweeps_reg = data[15:0];
      CFG_SOURCE_SCALE: scale_reg = data;
      default: ;
    endcase
  endtask

  function automatic logic signed [39:0] rand_cell();
    case ($urandom_range(7))
      0: return CELL_MAX;
      1: return CELL_MIN;
      2, 3: return $signed(40'($urandom_range(2000000))) - 40'sd1000000;
      default: return 40'({$urandom, $urandom});
    endcase
  endfunction

  // Load every cell of the n by n grid, then mix writes, reads, runs and noise.
  task automatic random_phase(input int n, input int items);
    int pick;
    logic [6:0] r;
    logic [6:0] c;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) send_item(OP_WRITE, 7'(i), 7'(j), rand_cell(), 1'b0, '0);
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      r = 7'($urandom_range(127));
      c = 7'($urandom_range(127));
      if (pick < 35) begin
        if (pick < 15) begin
          r = 7'($urandom_range(n - 1));
          c = 7'($urandom_range(n - 1));
        end
        send_item(OP_WRITE, r, c, rand_cell(), 1'b0, '0);
      end else if (pick < 80) begin
        if (!cell_written[r*GRID_MAX+c] || pick < 60) begin
          r = 7'($urandom_range(n - 1));
          c = 7'($urandom_range(n - 1));
        end
        send_item(OP_READ, r, c, 40'({$urandom, $urandom}), 1'b0, '0);
      end else if (pick < 92) begin
        send_item(OP_RUN, r, c, 40'({$urandom, $urandom}), 1'b0, '0);
      end else begin
        send_item(OP_UNUSED, r, c, 40'({$urandom, $urandom}), 1'b0, '0);
      end
    end
    drain();
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Compare each accepted reply with the oldest expectation; watch for hangs.
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("grid_relaxation_stencil_top test failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected reply: cell %h read %b",
                                         cell_out, is_read_reply);
        end else begin
          want = reply_q.pop_front();
          if (cell_out !== want.val || is_read_reply !== want.read_reply) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply mismatch: expected cell %h read %b, got cell %h read %b",
                       want.val, want.read_reply, cell_out, is_read_reply);
          end
        end
      end
    end
  end

  initial begin
    reply_t want;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_WRITE;
    row = '0;
    col = '0;
    cell_in = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GRID_SIZE;
    cfg_data = '0;
    send_idle = 20;
    recv_idle = 82;
    size_reg = 8'd128;
    sweeps_reg = 16'd1001;
    scale_reg = 32'd258096;
    for (int i = 0; i < GRID_MAX*GRID_MAX; i++) begin
      grid_now[i] = '0;
      grid_old[i] = '0;
      source_term[i] = '0;
      cell_written[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part on a 3 by 3 grid with the largest scale.
    write_reg(CFG_GRID_SIZE, 32'd3);
    write_reg(CFG_SWEEP_COUNT, 32'd1);
    write_reg(CFG_SOURCE_SCALE, 32'hFFFF_FFFF);
    for (int i = 0; i < DIR_ROWS; i++) begin
      want.val = dir_tab[i].want_cell;
      want.read_reply = dir_tab[i].want_read;
      send_item(dir_tab[i].op, dir_tab[i].row, dir_tab[i].col, dir_tab[i].val,
                dir_tab[i].typed, want);
    end
    drain();

    // Grids too small for interior cells still answer done, even at most sweeps.
    write_reg(CFG_SWEEP_COUNT, 32'd65535);
    write_reg(CFG_GRID_SIZE, 32'd2);
    send_item(OP_RUN, 7'd0, 7'd0, '0, 1'b0, '0);
    drain();
    write_reg(CFG_GRID_SIZE, 32'd0);
    send_item(OP_RUN, 7'd0, 7'd0, '0, 1'b0, '0);
    drain();

    // Random phases under changing settings and idling.
    write_reg(CFG_GRID_SIZE, 32'd5);
    write_reg(CFG_SWEEP_COUNT, 32'd2);
    write_reg(CFG_SOURCE_SCALE, $urandom);
    random_phase(5, 55);
    write_reg(CFG_GRID_SIZE, 32'd4);
    write_reg(CFG_SWEEP_COUNT, 32'd3);
    write_reg(CFG_SOURCE_SCALE, 32'd0);
    random_phase(4, 50);
    send_idle = 82;
    recv_idle = 20;
    write_reg(CFG_GRID_SIZE, 32'd6);
    write_reg(CFG_SWEEP_COUNT, 32'd1);
    write_reg(CFG_SOURCE_SCALE, 32'd258096);
    random_phase(6, 55);
    write_reg(CFG_GRID_SIZE, 32'd3);
    write_reg(CFG_SWEEP_COUNT, 32'd0);
    random_phase(3, 40);
    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_GRID_SIZE, 32'd7);
    write_reg(CFG_SWEEP_COUNT, 32'd2);
    write_reg(CFG_SOURCE_SCALE, $urandom);
    random_phase(7, 55);

    // Oversized grid setting with no sweeps still answers done, without sweeping.
    write_reg(CFG_GRID_SIZE, 32'd255);
    write_reg(CFG_SWEEP_COUNT, 32'd0);
    send_item(OP_RUN, 7'd0, 7'd0, '0, 1'b0, '0);
    drain();

    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("grid_relaxation_stencil_top test passed");
    end else begin
      $display("grid_relaxation_stencil_top test failed");
    end
    $finish;
  end
endmodule

// ===== grid_relaxation_stencil_top.f =====
design/grs_pkg.sv
design/grs_ctrl.sv
design/grs_datapath.sv
design/grid_relaxation_stencil_top.sv
test/testbench.sv
